FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level crossfade interpolator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: sv/dci_pkg.sv
package dci_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;

    localparam logic [8:0]  WEIGHT_FULL = 9'd256;
    localparam logic [8:0]  WEIGHT_HALF = 9'd128;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [2:0]  DIV_LAST    = 3'd7;

    typedef struct packed {
        logic mem_wr;
        logic start;
        logic cancel;
        logic tick;
        logic div_init;
        logic div_step;
        logic rd;
        logic mul;
        logic out_load;
    } dci_cmd_t;

    typedef struct packed {
        logic fade_on;
        logic elapsed_ge;
        logic div_last;
        logic out_free;
        logic weight_full;
    } dci_status_t;

endpackage

FILE: sv/dci_ctrl.sv
module dci_ctrl
    import dci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  operation,
    input  dci_status_t st,
    output logic        in_stall,
    output dci_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DIV_INIT = 5'b00010,
        S_DIV      = 5'b00100,
        S_MUL      = 5'b01000,
        S_OUT      = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_LOAD:   cmd.mem_wr = 1'b1;
                        OP_START:  cmd.start  = 1'b1;
                        OP_CANCEL: cmd.cancel = 1'b1;
                        OP_TICK:
                        begin
                            if (st.fade_on)
                            begin
                                cmd.tick   = 1'b1;
                                state_next = S_DIV_INIT;
                            end
                        end
                        OP_READ:
                        begin
                            if (st.fade_on)
                            begin
                                cmd.rd     = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = st.elapsed_ge ? S_IDLE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: sv/dci_datapath.sv
module dci_datapath
    import dci_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dci_cmd_t    cmd,
    input  logic [8:0]  channel,
    input  logic [7:0]  from_value,
    input  logic [7:0]  to_value,
    input  logic        snap_channel,
    input  logic [15:0] duration_ms,
    input  logic        out_stall,
    output dci_status_t st,
    output logic        out_valid,
    output logic [7:0]  level,
    output logic        written,
    output logic        fading,
    output logic        finished
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [15:0] CH_LIMIT = 16'(CHANNELS);

    typedef struct packed {
        logic       snap;
        logic [7:0] to_lvl;
        logic [7:0] from_lvl;
    } dci_entry_t;

    dci_entry_t mem [CHANNELS];

    logic [15:0]        elapsed_reg;
    logic [15:0]        length_reg;
    logic               fade_on_reg;
    logic [8:0]         weight_reg;
    logic [16:0]        rem_reg;
    logic [7:0]         quo_reg;
    logic [2:0]         step_reg;
    dci_entry_t         rd_entry_reg;
    logic               in_range_reg;
    logic               done_reg;
    logic signed [18:0] prod_reg;
    logic               out_valid_reg;
    logic [7:0]         level_reg;
    logic               done_out_reg;

    logic [15:0]        ch_wide;
    logic [AW-1:0]      addr;
    logic               in_range;
    logic               elapsed_ge;
    logic [16:0]        rem_sh;
    logic               quo_bit;
    logic [16:0]        rem_next;
    logic [7:0]         quo_next;
    logic signed [8:0]  diff;
    logic signed [18:0] prod_next;
    logic signed [18:0] step_full;
    logic signed [18:0] lvl_full;
    logic [7:0]         level_next;
    logic               out_free;

    assign ch_wide    = {7'd0, channel};
    assign addr       = ch_wide[AW-1:0];
    assign in_range   = (ch_wide < CH_LIMIT);
    assign elapsed_ge = (elapsed_reg >= length_reg);

    // Restoring division of elapsed*256 by the fade length, one quotient bit per step.
    assign rem_sh   = {rem_reg[15:0], 1'b0};
    assign quo_bit  = (rem_sh >= {1'b0, length_reg});
    assign rem_next = quo_bit ? (rem_sh - {1'b0, length_reg}) : rem_sh;
    assign quo_next = {quo_reg[6:0], quo_bit};

    assign diff      = $signed({1'b0, rd_entry_reg.to_lvl}) - $signed({1'b0, rd_entry_reg.from_lvl});
    assign prod_next = diff * $signed({1'b0, weight_reg});

    // The quotient by 256 truncates toward zero, so negative products are biased first.
    assign step_full = prod_reg[18] ? ((prod_reg + 19'sd255) >>> 8) : (prod_reg >>> 8);
    assign lvl_full  = $signed({11'd0, rd_entry_reg.from_lvl}) + step_full;

    always_comb
    begin
        if (!in_range_reg)
        begin
            level_next = 8'd0;
        end
        else if (done_reg)
        begin
            level_next = rd_entry_reg.to_lvl;
        end
        else if (rd_entry_reg.snap)
        begin
            level_next = (weight_reg >= WEIGHT_HALF) ? rd_entry_reg.to_lvl
                                                     : rd_entry_reg.from_lvl;
        end
        else
        begin
            level_next = lvl_full[7:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && in_range)
        begin
            mem[addr] <= '{snap: snap_channel, to_lvl: to_value, from_lvl: from_value};
        end
        if (cmd.rd)
        begin
            rd_entry_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            in_range_reg <= in_range;
            done_reg     <= elapsed_ge;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= {1'b0, elapsed_reg};
            quo_reg  <= 8'd0;
            step_reg <= 3'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg + 3'd1;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            level_reg    <= level_next;
            done_out_reg <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= 16'd0;
            length_reg    <= 16'd0;
            fade_on_reg   <= 1'b0;
            weight_reg    <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                if (duration_ms == 16'd0)
                begin
                    fade_on_reg <= 1'b0;
                end
                else
                begin
                    length_reg  <= duration_ms;
                    elapsed_reg <= 16'd0;
                    fade_on_reg <= 1'b1;
                    weight_reg  <= 9'd0;
                end
            end
            if (cmd.cancel)
            begin
                fade_on_reg <= 1'b0;
            end
            if (cmd.tick && (elapsed_reg != COUNT_MAX))
            begin
                elapsed_reg <= elapsed_reg + 16'd1;
            end
            if (cmd.div_init && elapsed_ge)
            begin
                weight_reg <= WEIGHT_FULL;
            end
            if (cmd.div_step && (step_reg == DIV_LAST))
            begin
                weight_reg <= {1'b0, quo_next};
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.fade_on     = fade_on_reg;
    assign st.elapsed_ge  = elapsed_ge;
    assign st.div_last    = (step_reg == DIV_LAST);
    assign st.out_free    = out_free;
    assign st.weight_full = weight_reg[8];

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign written   = out_valid_reg;
    assign fading    = !done_out_reg;
    assign finished  = done_out_reg;

endmodule

FILE: sv/dmx_crossfade_interpolator.sv
// Crossfade engine for DMX frames. Load requests store one channel's source level, target
// level and snap bit; a start request with a nonzero duration begins a fade, and a start with
// zero duration or a cancel request ends it. Ticks during a fade advance the millisecond
// counter, and a read request during a fade returns the channel's level at the current time,
// with finished set once the counter has reached the duration. Reads while no fade runs, and
// all other requests, give no response; load, start, cancel and idle ticks never stall the
// input. A tick during a fade starts the restoring divider, which recomputes the fade weight
// one quotient bit per cycle, or sets the full weight at once at the end of the fade. A read
// passes the registered channel memory read, the weight multiply, and the output register,
// which holds a response until the downstream side takes it while the next request is taken.
`include "assert_macros.svh"

module dmx_crossfade_interpolator
    import dci_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [8:0]  channel,
    input  logic [7:0]  from_value,
    input  logic [7:0]  to_value,
    input  logic        snap_channel,
    input  logic [15:0] duration_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  level,
    output logic        written,
    output logic        fading,
    output logic        finished
);

    dci_cmd_t    cmd;
    dci_status_t st;

    dci_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .st        (st),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    dci_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .channel      (channel),
        .from_value   (from_value),
        .to_value     (to_value),
        .snap_channel (snap_channel),
        .duration_ms  (duration_ms),
        .out_stall    (out_stall),
        .st           (st),
        .out_valid    (out_valid),
        .level        (level),
        .written      (written),
        .fading       (fading),
        .finished     (finished)
    );

    `ASSERT_IMPLY(a_flags_exclusive, out_valid, fading != finished)
    `ASSERT_NEXT(a_read_busy, in_valid && !in_stall && (operation == OP_READ) && st.fade_on, in_stall)
    `ASSERT_IMPLY(a_weight_below_full, !in_stall && st.fade_on && !st.elapsed_ge, !st.weight_full)

endmodule

FILE: verif/tb.sv
module tb;
    import dci_pkg::*;

    localparam int CHANNELS     = 512;
    localparam int RANDOM_ITEMS = 1350;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int OVERRUN_TICKS = 20;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] level;
        logic       fading;
        logic       finished;
    } channel_level_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_HEAVY, RX_PATTERN} rx_mode_t;

    class fade_scoreboard;
        bit [7:0]  source_levels [CHANNELS];
        bit [7:0]  target_levels [CHANNELS];
        bit        snap_flags [CHANNELS];
        bit [15:0] elapsed_ms;
        bit [15:0] fade_ms;
        bit        active;
        bit [8:0]  weight;
        channel_level_t pending_levels[$];
        int        errors;

        function void refresh_weight();
            int unsigned ratio;
            ratio = 0;
            if (fade_ms != 0)
            begin
                ratio = (32'(elapsed_ms) * 32'(WEIGHT_FULL)) / 32'(fade_ms);
                if (ratio > 32'(WEIGHT_FULL))
                begin
                    ratio = 32'(WEIGHT_FULL);
                end
            end
            weight = ratio[8:0];
        endfunction

        function bit [7:0] glide(bit [7:0] src, bit [7:0] dst);
            int diff;
            int lvl;
            diff = int'(dst) - int'(src);
            lvl = int'(src) + (diff * int'(weight)) / int'(WEIGHT_FULL);
            if (lvl < 0)
            begin
                lvl = 0;
            end
            if (lvl > 255)
            begin
                lvl = 255;
            end
            return lvl[7:0];
        endfunction

        function void note_request(logic [2:0] op, logic [8:0] ch, logic [7:0] fv,
                                   logic [7:0] tv, logic sn, logic [15:0] dur);
            channel_level_t want;
            bit done;
            case (op)
                OP_LOAD:
                begin
                    if (ch < CHANNELS)
                    begin
                        source_levels[ch] = fv;
                        target_levels[ch] = tv;
                        snap_flags[ch] = sn;
                    end
                end
                OP_START:
                begin
                    if (dur == 0)
                    begin
                        active = 1'b0;
                    end
                    else
                    begin
                        fade_ms = dur;
                        elapsed_ms = '0;
                        active = 1'b1;
                        refresh_weight();
                    end
                end
                OP_TICK:
                begin
                    if (active)
                    begin
                        if (elapsed_ms != COUNT_MAX)
                        begin
                            elapsed_ms++;
                        end
                        refresh_weight();
                    end
                end
                OP_CANCEL:
                begin
                    active = 1'b0;
                end
                OP_READ:
                begin
                    if (active)
                    begin
                        done = (elapsed_ms >= fade_ms);
                        want.level = 8'd0;
                        if (ch < CHANNELS)
                        begin
                            if (done)
                            begin
                                want.level = target_levels[ch];
                            end
                            else if (snap_flags[ch])
                            begin
                                want.level = (weight >= WEIGHT_HALF) ? target_levels[ch]
                                                                     : source_levels[ch];
                            end
                            else
                            begin
                                want.level = glide(source_levels[ch], target_levels[ch]);
                            end
                        end
                        want.fading = !done;
                        want.finished = done;
                        pending_levels.push_back(want);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(logic [7:0] lvl, logic wr, logic fd, logic fn);
            channel_level_t want;
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual level %0d", $time, lvl);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            compare_field("level", want.level, lvl);
            compare_field("written", 8'd1, 8'(wr));
            compare_field("fading", 8'(want.fading), 8'(fd));
            compare_field("finished", 8'(want.finished), 8'(fn));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [8:0]  channel;
    logic [7:0]  from_value;
    logic [7:0]  to_value;
    logic        snap_channel;
    logic [15:0] duration_ms;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  level;
    logic        written;
    logic        fading;
    logic        finished;

    fade_scoreboard scoreboard;
    int burst_left;
    bit gaps_on;
    int items_sent;
    int idle_cycles;
    bit is_loaded [CHANNELS];
    int loaded_channels[$];
    rx_mode_t stall_mode;
    int stall_left;
    logic [7:0] stall_pattern;

    dmx_crossfade_interpolator #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .channel(channel),
        .from_value(from_value),
        .to_value(to_value),
        .snap_channel(snap_channel),
        .duration_ms(duration_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .level(level),
        .written(written),
        .fading(fading),
        .finished(finished)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                scoreboard.check_response(level, written, fading, finished);
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                scoreboard.note_request(operation, channel, from_value, to_value,
                                        snap_channel, duration_ms);
            end
            if ((in_valid === 1'b1 && in_stall === 1'b0)
                || (out_valid === 1'b1 && out_stall === 1'b0))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(3, 0));
            stall_left = $urandom_range(300, 20);
            stall_pattern = 8'($urandom);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            RX_OPEN:
            begin
                out_stall <= 1'b0;
            end
            RX_RANDOM:
            begin
                out_stall <= ($urandom_range(1, 0) == 1);
            end
            RX_HEAVY:
            begin
                out_stall <= ($urandom_range(4, 0) != 0);
            end
            default:
            begin
                out_stall <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
        endcase
    end

    task automatic send_req(input logic [2:0] op, input logic [8:0] ch, input logic [7:0] fv,
                            input logic [7:0] tv, input logic sn, input logic [15:0] dur);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (op <= OP_CANCEL)
        begin
            items_sent++;
        end
        in_valid <= 1'b1;
        operation <= op;
        channel <= ch;
        from_value <= fv;
        to_value <= tv;
        snap_channel <= sn;
        duration_ms <= dur;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic load_channel(input logic [8:0] ch, input logic [7:0] fv,
                                input logic [7:0] tv, input logic sn);
        if (ch < CHANNELS && !is_loaded[ch])
        begin
            is_loaded[ch] = 1'b1;
            loaded_channels.push_back(int'(ch));
        end
        send_req(OP_LOAD, ch, fv, tv, sn, 16'($urandom));
    endtask

    function automatic logic [8:0] any_loaded();
        return 9'(loaded_channels[$urandom_range(loaded_channels.size() - 1, 0)]);
    endfunction

    task automatic send_plain(input logic [2:0] op, input logic [15:0] dur);
        send_req(op, any_loaded(), 8'($urandom), 8'($urandom), 1'($urandom), dur);
    endtask

    task automatic send_noise();
        logic [2:0] op;
        logic [15:0] dur;
        op = 3'($urandom_range(OP_SPARE_HI, 0));
        dur = ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom);
        if (op == OP_LOAD)
        begin
            load_channel(9'($urandom_range(CHANNELS - 1, 0)), 8'($urandom), 8'($urandom),
                         1'($urandom));
        end
        else
        begin
            send_plain(op, dur);
        end
    endtask

    task automatic run_fade_sequence();
        int steps;
        int pick;
        logic [15:0] dur;
        repeat ($urandom_range(6, 0))
        begin
            load_channel(9'($urandom_range(CHANNELS - 1, 0)), 8'($urandom), 8'($urandom),
                         1'($urandom));
        end
        pick = $urandom_range(19, 0);
        if (pick < 2)
        begin
            dur = 16'($urandom);
            if (dur == 0)
            begin
                dur = 16'd1;
            end
            steps = $urandom_range(40, 4);
        end
        else
        begin
            dur = 16'($urandom_range(48, 1));
            steps = $urandom_range(2 * int'(dur) + 8, 2);
        end
        send_plain(OP_START, dur);
        repeat (steps)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 4)
            begin
                send_plain(OP_TICK, 16'($urandom));
            end
            else if (pick < 8)
            begin
                send_plain(OP_READ, 16'($urandom));
            end
            else if (pick == 8)
            begin
                load_channel(9'($urandom_range(CHANNELS - 1, 0)), 8'($urandom), 8'($urandom),
                             1'($urandom));
            end
            else
            begin
                send_noise();
            end
        end
        pick = $urandom_range(3, 0);
        if (pick == 0)
        begin
            send_plain(OP_CANCEL, 16'($urandom));
        end
        else if (pick == 1)
        begin
            send_plain(OP_START, 16'd0);
        end
    endtask

    initial
    begin
        scoreboard = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        channel = '0;
        from_value = '0;
        to_value = '0;
        snap_channel = 1'b0;
        duration_ms = '0;
        out_stall = 1'b0;
        burst_left = 0;
        gaps_on = 1'b1;
        items_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_channel(9'd0, 8'd0, 8'd255, 1'b0);
        load_channel(9'd511, 8'd255, 8'd0, 1'b1);
        load_channel(9'h0AA, 8'hAA, 8'h55, 1'b0);
        load_channel(9'h155, 8'h55, 8'hAA, 1'b1);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++)
        begin
            send_plain(3'(op), 16'($urandom));
        end
        send_req(OP_START, 9'd0, 8'd0, 8'd0, 1'b0, 16'd4);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'd511, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'd511, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'h0AA, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        load_channel(9'd0, 8'd10, 8'd20, 1'b1);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_START, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_START, 9'd0, 8'd0, 8'd0, 1'b0, 16'hFFFF);
        send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'h155, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_CANCEL, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);

        // Keep ticking well past the end of a one millisecond fade.
        gaps_on = 1'b0;
        send_req(OP_START, 9'd0, 8'd0, 8'd0, 1'b0, 16'd1);
        repeat (OVERRUN_TICKS)
        begin
            send_req(OP_TICK, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        end
        send_req(OP_READ, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_READ, 9'h0AA, 8'd0, 8'd0, 1'b0, 16'd0);
        send_req(OP_CANCEL, 9'd0, 8'd0, 8'd0, 1'b0, 16'd0);
        gaps_on = 1'b1;

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                send_noise();
            end
            else
            begin
                run_fade_sequence();
            end
        end
        in_valid <= 1'b0;

        while (scoreboard.pending_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.pending_levels.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
